[rtl/crcdf_pkg.sv]
// ---------------------------------------------------------------------------
// crcdf_pkg: shared types and constants for the framed CRC-16 deframer
// Word formats, configuration register indexes, event codes and the
// frame phase encoding.
// ---------------------------------------------------------------------------
package crcdf_pkg;

	// Input word: one received byte or one timer tick
	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_word_t;

	// Result word: one per input word
	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] data_byte;
		logic [7:0] frame_type;
		logic [7:0] payload_count;
	} out_word_t;

	// Configuration register file contents
	typedef struct packed {
		logic [7:0]  header_byte;
		logic [7:0]  footer_byte;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// Configuration register indexes
	localparam logic [1:0] REG_HEADER  = 2'd0;
	localparam logic [1:0] REG_FOOTER  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic [7:0]  HEADER_RST  = 8'hAA;
	localparam logic [7:0]  FOOTER_RST  = 8'h55;
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;

	// Item kinds
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Event codes
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_PAYLOAD  = 3'd1;
	localparam logic [2:0] EV_GOOD     = 3'd2;
	localparam logic [2:0] EV_BAD_LEN  = 3'd3;
	localparam logic [2:0] EV_CRC_ERR  = 3'd4;
	localparam logic [2:0] EV_FOOT_ERR = 3'd5;
	localparam logic [2:0] EV_TIMEOUT  = 3'd6;
	localparam logic [2:0] EV_RESTART  = 3'd7;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Tick counter width and saturation value
	localparam int          TICK_W   = 17;
	localparam logic [16:0] TICK_TOP = 17'h1FFFF;

	// Frame phase
	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_CRCH = 3'd4,
		PH_CRCL = 3'd5,
		PH_FOOT = 3'd6
	} phase_t;

endpackage

[rtl/crc16_serial_frame_deframer.sv]
// ---------------------------------------------------------------------------
// crc16_serial_frame_deframer: framed byte-stream receiver, CRC-16 check
// Input register, combinational frame decode, result register.
// ---------------------------------------------------------------------------
// Words pass the input stage register, then the result stage register, to the output.
// One word per cycle unless out_ready stalls; byte CRC update is one unrolled stage.
// Each input word yields exactly one result word.
// Reset (arst_n low): pipeline empty, phase waits for header, CRC = 0xFFFF,
// registers return to header 0xAA, footer 0x55, timeout 1000 ticks.
module crc16_serial_frame_deframer #(
	parameter int MAX_PAYLOAD = 128
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  crcdf_pkg::in_word_t                    in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output crcdf_pkg::out_word_t                   out_data,
	input  logic                                   cfg_we,
	input  logic [crcdf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [crcdf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import crcdf_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	in_word_t  item_s1;
	logic      valid_s2;
	out_word_t res_s2;
	out_word_t res_d;
	logic      adv_s1;

	// Stage 1 moves on when the result register is free or draining
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte   <= HEADER_RST;
			cfg_q.footer_byte   <= FOOTER_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER:  cfg_q.header_byte   <= cfg_wdata[7:0];
				REG_FOOTER:  cfg_q.footer_byte   <= cfg_wdata[7:0];
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
	end

	crcdf_fsm #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_d)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) res_s2 <= res_d;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

[rtl/crcdf_crc.sv]
// ---------------------------------------------------------------------------
// crcdf_crc: one-byte CRC-16 update
// Eight unrolled MSB-first shift/xor steps, polynomial 0x1021.
// ---------------------------------------------------------------------------
module crcdf_crc (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import crcdf_pkg::*;

	// Fold the byte into the high half, then shift out eight bits
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

[rtl/crcdf_fsm.sv]
// ---------------------------------------------------------------------------
// crcdf_fsm: frame state machine and per-word result logic
// Holds the frame state, decodes one word per step and forms its result.
// ---------------------------------------------------------------------------
module crcdf_fsm #(
	parameter int MAX_PAYLOAD = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  crcdf_pkg::in_word_t  item,
	input  crcdf_pkg::cfg_t      cfg,
	output crcdf_pkg::out_word_t result
);
	import crcdf_pkg::*;

	localparam logic [8:0] LEN_MAX = 9'(MAX_PAYLOAD + 1);

	phase_t        phase_q, phase_d;
	logic [7:0]    bytes_left_q, bytes_left_d;
	logic [7:0]    type_q, type_d;
	logic [7:0]    seen_q, seen_d;
	logic [15:0]   crc_q, crc_d;
	logic [7:0]    crc_hi_q, crc_hi_d;
	logic [TICK_W-1:0] ticks_q, ticks_d;

	logic          is_tick;
	logic          hdr;
	logic [15:0]   crc_fed;
	logic [7:0]    left_dec;
	logic [7:0]    seen_inc;
	logic [TICK_W-1:0] ticks_inc;
	logic          len_ok;
	logic          timed_out;

	crcdf_crc u_crc (
		.crc_in  (crc_q),
		.data    (item.rx_byte),
		.crc_out (crc_fed)
	);

	// Shared decode terms
	assign is_tick   = (item.cmd == CMD_TICK);
	assign hdr       = (item.rx_byte == cfg.header_byte);
	assign left_dec  = bytes_left_q - 8'd1;
	assign seen_inc  = seen_q + 8'd1;
	assign ticks_inc = (ticks_q == TICK_TOP) ? ticks_q : ticks_q + 1'b1;
	assign len_ok    = (item.rx_byte != 8'd0) && ({1'b0, item.rx_byte} <= LEN_MAX);
	assign timed_out = (phase_q != PH_WAIT) && (ticks_inc > {1'b0, cfg.timeout_ticks});

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (is_tick) begin
			if (timed_out) phase_d = PH_WAIT;
		end else begin
			case (phase_q)
				PH_WAIT: if (hdr) phase_d = PH_LEN;
				PH_LEN:  phase_d = len_ok ? PH_TYPE : PH_WAIT;
				PH_TYPE: begin
					if (hdr) phase_d = PH_LEN;
					else phase_d = (left_dec == 8'd0) ? PH_CRCH : PH_DATA;
				end
				PH_DATA: begin
					if (hdr && seen_q == 8'd0) phase_d = PH_LEN;
					else if (left_dec == 8'd0) phase_d = PH_CRCH;
				end
				PH_CRCH: phase_d = hdr ? PH_LEN : PH_CRCL;
				PH_CRCL: begin
					if (hdr) phase_d = PH_LEN;
					else if ({crc_hi_q, item.rx_byte} == crc_q) phase_d = PH_FOOT;
					else phase_d = PH_WAIT;
				end
				PH_FOOT: phase_d = PH_WAIT;
				default: phase_d = PH_WAIT;
			endcase
		end
	end

	// Datapath updates and result word
	always_comb begin
		bytes_left_d = bytes_left_q;
		type_d       = type_q;
		seen_d       = seen_q;
		crc_d        = crc_q;
		crc_hi_d     = crc_hi_q;
		result       = '0;
		if (is_tick) begin
			ticks_d = timed_out ? '0 : ticks_inc;
			if (timed_out) result.event_res = EV_TIMEOUT;
		end else begin
			ticks_d = (phase_d != phase_q) ? '0 : ticks_q;
			case (phase_q)
				PH_WAIT: ;
				PH_LEN: begin
					if (len_ok) begin
						bytes_left_d = item.rx_byte;
						seen_d       = 8'd0;
						crc_d        = CRC_INIT;
					end else begin
						result.event_res = EV_BAD_LEN;
					end
				end
				PH_TYPE: begin
					if (hdr) begin
						result.event_res = EV_RESTART;
					end else begin
						type_d       = item.rx_byte;
						crc_d        = crc_fed;
						bytes_left_d = left_dec;
					end
				end
				PH_DATA: begin
					if (hdr && seen_q == 8'd0) begin
						result.event_res = EV_RESTART;
					end else begin
						crc_d                = crc_fed;
						seen_d               = seen_inc;
						bytes_left_d         = left_dec;
						result.event_res     = EV_PAYLOAD;
						result.data_byte     = item.rx_byte;
						result.payload_count = seen_inc;
					end
				end
				PH_CRCH: begin
					if (hdr) result.event_res = EV_RESTART;
					else crc_hi_d = item.rx_byte;
				end
				PH_CRCL: begin
					if (hdr) result.event_res = EV_RESTART;
					else if ({crc_hi_q, item.rx_byte} != crc_q) result.event_res = EV_CRC_ERR;
				end
				PH_FOOT: begin
					if (item.rx_byte == cfg.footer_byte) begin
						result.event_res     = EV_GOOD;
						result.frame_type    = type_q;
						result.payload_count = seen_q;
					end else begin
						result.event_res = EV_FOOT_ERR;
					end
				end
				default: ;
			endcase
		end
	end

	// State registers, updated once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			bytes_left_q <= '0;
			type_q       <= '0;
			seen_q       <= '0;
			crc_q        <= CRC_INIT;
			crc_hi_q     <= '0;
			ticks_q      <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			type_q       <= type_d;
			seen_q       <= seen_d;
			crc_q        <= crc_d;
			crc_hi_q     <= crc_hi_d;
			ticks_q      <= ticks_d;
		end
	end

endmodule
